@@ rtl/core/sdf_pkg.sv @@
// shared widths, config register codes and sideband types for the spring-damper force block
// no dependencies; used by the top level and the pipelined divider's users

package sdf_pkg;

    localparam int DATA_W     = 32;               // port width of every Q16.16 field
    localparam int FRAC_W     = 16;               // fraction bits of Q16.16
    localparam int DIFF_W     = 33;               // r and v components, signed
    localparam int MAG_W      = 32;               // magnitude of one component
    localparam int PROD_W     = 64;               // component products
    localparam int SUM_W      = 66;               // sum of three products
    localparam int ROOT_BITS  = 34;               // one square-root stage per result bit
    localparam int SQ_PAD_W   = 2 * ROOT_BITS;    // radicand padded to bit pairs
    localparam int SQ_REM_W   = 36;               // partial remainder of the root
    localparam int LEN_W      = 33;               // |r| in units of 2^-16
    localparam int RATIO_W    = 34;               // (v.r)/|r|
    localparam int SMAG_W     = 34;               // | |r| - rest |
    localparam int GPROD_W    = 66;               // gain times a 34-bit magnitude
    localparam int TERM_W     = GPROD_W - FRAC_W; // spring or damper term magnitude
    localparam int FS_W       = 52;               // scalar force, signed
    localparam int FS_HALF_W  = FS_W / 2;         // split of |f| for partial products
    localparam int PART_W     = FS_HALF_W + MAG_W;
    localparam int NUM_W      = FS_W + MAG_W;     // |f|*|r_i|
    localparam int QF_W       = 33;               // force quotient bits before saturation
    localparam int QFN_W      = QF_W + LEN_W;     // force divider numerator
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPRING_GAIN = 2'd0,
        CFG_DAMPER_GAIN = 2'd1,
        CFG_REST_LENGTH = 2'd2
    } cfg_index_t;

    typedef logic [2:0][MAG_W-1:0] mag3_t;

    // carried alongside the square root
    typedef struct packed {
        logic [SUM_W-1:0] dmag;
        logic             dneg;
        logic             deg;
        mag3_t            rm;
        logic [2:0]       rneg;
    } sqrt_side_t;

    // carried alongside the damping ratio divider
    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic             dneg;
        logic             deg;
        mag3_t            rm;
        logic [2:0]       rneg;
    } ratio_side_t;

    // carried alongside each force component divider
    typedef struct packed {
        logic negf;
        logic ovf;
        logic deg;
    } force_side_t;

endpackage

@@ rtl/core/sdf_div_pipe.sv @@
// pipelined restoring divider, one quotient bit per register stage, with a sideband lane
// no package dependency; numerator must satisfy num < den * 2^QUO_W

module sdf_div_pipe #(
    parameter int NUM_W  = 66,
    parameter int DEN_W  = 33,
    parameter int QUO_W  = 34,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic [SIDE_W-1:0] side_out
);

    logic              vld_reg  [1:QUO_W];
    logic [DEN_W-1:0]  rem_reg  [1:QUO_W];
    logic [DEN_W-1:0]  den_reg  [1:QUO_W];
    logic [QUO_W-1:0]  bits_reg [1:QUO_W];
    logic [QUO_W-1:0]  q_reg    [1:QUO_W];
    logic [SIDE_W-1:0] side_reg [1:QUO_W];

    for (genvar k = 0; k < QUO_W; k++) begin : g_stage
        logic              vld_cur;
        logic [DEN_W-1:0]  rem_cur;
        logic [DEN_W-1:0]  den_cur;
        logic [QUO_W-1:0]  bits_cur;
        logic [QUO_W-1:0]  q_cur;
        logic [SIDE_W-1:0] side_cur;
        logic [DEN_W:0]    rem_sh;
        logic              ge;
        logic [DEN_W-1:0]  rem_next;
        logic [QUO_W-1:0]  bits_next;
        logic [QUO_W-1:0]  q_next;

        if (k == 0) begin : g_first
            assign vld_cur  = in_valid;
            assign rem_cur  = DEN_W'(num >> QUO_W);
            assign den_cur  = den;
            assign bits_cur = num[QUO_W-1:0];
            assign q_cur    = '0;
            assign side_cur = side_in;
        end else begin : g_rest
            assign vld_cur  = vld_reg[k];
            assign rem_cur  = rem_reg[k];
            assign den_cur  = den_reg[k];
            assign bits_cur = bits_reg[k];
            assign q_cur    = q_reg[k];
            assign side_cur = side_reg[k];
        end

        // shift in the next numerator bit, subtract when it fits
        assign rem_sh    = {rem_cur, bits_cur[QUO_W-1]};
        assign ge        = rem_sh >= {1'b0, den_cur};
        assign rem_next  = ge ? DEN_W'(rem_sh - {1'b0, den_cur}) : DEN_W'(rem_sh);
        assign bits_next = {bits_cur[QUO_W-2:0], 1'b0};
        assign q_next    = {q_cur[QUO_W-2:0], ge};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                vld_reg[k+1] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k+1]  <= rem_next;
                den_reg[k+1]  <= den_cur;
                bits_reg[k+1] <= bits_next;
                q_reg[k+1]    <= q_next;
                side_reg[k+1] <= side_cur;
            end
        end
    end

    assign out_valid = vld_reg[QUO_W];
    assign quo       = q_reg[QUO_W];
    assign side_out  = side_reg[QUO_W];

endmodule

@@ rtl/core/spring_damper_force_top.sv @@
// spring-damper force between two particles, deep pipeline, one beat per cycle unless the output stalls
// depends on sdf_pkg and sdf_div_pipe

// usage
//   input channel s_*: one beat carries positions and velocities of particles a and b,
//   all signed Q16.16. result channel m_*: force on particle b (saturated Q16.16 per
//   component) plus a degenerate flag when the particles coincide; the force on a is
//   the negation. one result beat per input beat, in order.
//   config port: cfg_wr_en/cfg_index/cfg_data write spring gain (0), damper gain (1)
//   and rest length (2); other indexes are dropped. write only while the block is idle.
// throughput: one beat per cycle sustained while result beats are taken.
// pipeline: 5 front stages, 34 square-root stages, 34 ratio divider stages, 7 force
//   stages, 33 force divider stages and the output register. the dividers and the root
//   resolve one bit per stage.
// stall: the whole pipeline holds only when its last stage has a result and the output
//   register is full and not taken; while the last stage is empty the pipe keeps moving,
//   so s_ready stays high until the next result reaches the last divider stage.
// reset: synchronous active-low aresetn clears all valid bits and the config registers.

module spring_damper_force_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    // config
    input  logic                              cfg_wr_en,
    input  logic [sdf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [sdf_pkg::DATA_W-1:0]        cfg_data,
    // input beats
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_pos_a_x,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_pos_a_y,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_pos_a_z,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_pos_b_x,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_pos_b_y,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_pos_b_z,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_vel_a_x,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_vel_a_y,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_vel_a_z,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_vel_b_x,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_vel_b_y,
    input  logic signed [sdf_pkg::DATA_W-1:0] s_vel_b_z,
    // result beats
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [sdf_pkg::DATA_W-1:0] m_force_x,
    output logic signed [sdf_pkg::DATA_W-1:0] m_force_y,
    output logic signed [sdf_pkg::DATA_W-1:0] m_force_z,
    output logic                              m_degenerate
);

    localparam int DW   = sdf_pkg::DATA_W;
    localparam int RB   = sdf_pkg::ROOT_BITS;
    localparam int FW   = sdf_pkg::FRAC_W;

    // ---------------- config registers ----------------
    logic [DW-1:0] spring_gain_reg;
    logic [DW-1:0] damper_gain_reg;
    logic [DW-1:0] rest_length_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spring_gain_reg <= '0;
            damper_gain_reg <= '0;
            rest_length_reg <= '0;
        end else if (cfg_wr_en) begin
            case (sdf_pkg::cfg_index_t'(cfg_index))
                sdf_pkg::CFG_SPRING_GAIN: spring_gain_reg <= cfg_data;
                sdf_pkg::CFG_DAMPER_GAIN: damper_gain_reg <= cfg_data;
                sdf_pkg::CFG_REST_LENGTH: rest_length_reg <= cfg_data;
                default: ; // unknown index, write dropped
            endcase
        end
    end

    // ---------------- pipeline enable ----------------
    // hold everything only when the last stage is full and cannot move out
    logic en;
    logic last_vld;
    logic m_valid_reg;

    assign en      = !(last_vld && m_valid_reg && !m_ready);
    assign s_ready = en;

    // ---------------- p1: differences ----------------
    logic                       p1_vld_reg;
    logic [2:0][sdf_pkg::DIFF_W-1:0] p1_dr_reg;
    logic [2:0][sdf_pkg::DIFF_W-1:0] p1_dv_reg;
    logic [2:0][sdf_pkg::DIFF_W-1:0] p1_dr_next;
    logic [2:0][sdf_pkg::DIFF_W-1:0] p1_dv_next;

    // r = pa - pb, v = va - vb, exact in 33 bits
    always_comb begin
        p1_dr_next[0] = {s_pos_a_x[DW-1], s_pos_a_x} - {s_pos_b_x[DW-1], s_pos_b_x};
        p1_dr_next[1] = {s_pos_a_y[DW-1], s_pos_a_y} - {s_pos_b_y[DW-1], s_pos_b_y};
        p1_dr_next[2] = {s_pos_a_z[DW-1], s_pos_a_z} - {s_pos_b_z[DW-1], s_pos_b_z};
        p1_dv_next[0] = {s_vel_a_x[DW-1], s_vel_a_x} - {s_vel_b_x[DW-1], s_vel_b_x};
        p1_dv_next[1] = {s_vel_a_y[DW-1], s_vel_a_y} - {s_vel_b_y[DW-1], s_vel_b_y};
        p1_dv_next[2] = {s_vel_a_z[DW-1], s_vel_a_z} - {s_vel_b_z[DW-1], s_vel_b_z};
    end

    // ---------------- p2: magnitudes and signs ----------------
    logic                  p2_vld_reg;
    sdf_pkg::mag3_t        p2_rm_reg;
    sdf_pkg::mag3_t        p2_vm_reg;
    logic [2:0]            p2_rneg_reg;
    logic [2:0]            p2_pneg_reg;
    sdf_pkg::mag3_t        p2_rm_next;
    sdf_pkg::mag3_t        p2_vm_next;
    logic [2:0]            p2_rneg_next;
    logic [2:0]            p2_pneg_next;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p2_rneg_next[i] = p1_dr_reg[i][sdf_pkg::DIFF_W-1];
            p2_pneg_next[i] = p1_dr_reg[i][sdf_pkg::DIFF_W-1] ^ p1_dv_reg[i][sdf_pkg::DIFF_W-1];
            p2_rm_next[i]   = p2_rneg_next[i] ? sdf_pkg::MAG_W'(~p1_dr_reg[i] + 1'b1)
                                              : sdf_pkg::MAG_W'(p1_dr_reg[i]);
            p2_vm_next[i]   = p1_dv_reg[i][sdf_pkg::DIFF_W-1]
                            ? sdf_pkg::MAG_W'(~p1_dv_reg[i] + 1'b1)
                            : sdf_pkg::MAG_W'(p1_dv_reg[i]);
        end
    end

    // ---------------- p3: component products ----------------
    logic                                 p3_vld_reg;
    logic [2:0][sdf_pkg::PROD_W-1:0]      p3_sq_reg;
    logic [2:0][sdf_pkg::PROD_W-1:0]      p3_vr_reg;
    sdf_pkg::mag3_t                       p3_rm_reg;
    logic [2:0]                           p3_rneg_reg;
    logic [2:0]                           p3_pneg_reg;

    // ---------------- p4: sums ----------------
    logic                         p4_vld_reg;
    logic [sdf_pkg::SUM_W-1:0]    p4_s_reg;
    logic [sdf_pkg::SUM_W-1:0]    p4_pos_reg;
    logic [sdf_pkg::SUM_W-1:0]    p4_neg_reg;
    sdf_pkg::mag3_t               p4_rm_reg;
    logic [2:0]                   p4_rneg_reg;
    logic [sdf_pkg::SUM_W-1:0]    p4_pos_next;
    logic [sdf_pkg::SUM_W-1:0]    p4_neg_next;

    // v.r split into its positive and negative parts
    always_comb begin
        p4_pos_next = '0;
        p4_neg_next = '0;
        for (int i = 0; i < 3; i++) begin
            if (p3_pneg_reg[i]) begin
                p4_neg_next = p4_neg_next + sdf_pkg::SUM_W'(p3_vr_reg[i]);
            end else begin
                p4_pos_next = p4_pos_next + sdf_pkg::SUM_W'(p3_vr_reg[i]);
            end
        end
    end

    // ---------------- p5: |v.r| and its sign ----------------
    logic                         p5_vld_reg;
    logic [sdf_pkg::SUM_W-1:0]    p5_s_reg;
    sdf_pkg::sqrt_side_t          p5_side_reg;
    sdf_pkg::sqrt_side_t          p5_side_next;

    always_comb begin
        p5_side_next.dneg = p4_neg_reg > p4_pos_reg;
        p5_side_next.dmag = p5_side_next.dneg ? (p4_neg_reg - p4_pos_reg)
                                              : (p4_pos_reg - p4_neg_reg);
        p5_side_next.deg  = (p4_s_reg == '0);
        p5_side_next.rm   = p4_rm_reg;
        p5_side_next.rneg = p4_rneg_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
        end else if (en) begin
            p1_vld_reg <= s_valid;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= p4_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p1_dr_reg   <= p1_dr_next;
            p1_dv_reg   <= p1_dv_next;
            p2_rm_reg   <= p2_rm_next;
            p2_vm_reg   <= p2_vm_next;
            p2_rneg_reg <= p2_rneg_next;
            p2_pneg_reg <= p2_pneg_next;
            for (int i = 0; i < 3; i++) begin
                p3_sq_reg[i] <= p2_rm_reg[i] * p2_rm_reg[i];
                p3_vr_reg[i] <= p2_rm_reg[i] * p2_vm_reg[i];
            end
            p3_rm_reg   <= p2_rm_reg;
            p3_rneg_reg <= p2_rneg_reg;
            p3_pneg_reg <= p2_pneg_reg;
            p4_s_reg    <= sdf_pkg::SUM_W'(p3_sq_reg[0]) + sdf_pkg::SUM_W'(p3_sq_reg[1])
                         + sdf_pkg::SUM_W'(p3_sq_reg[2]);
            p4_pos_reg  <= p4_pos_next;
            p4_neg_reg  <= p4_neg_next;
            p4_rm_reg   <= p3_rm_reg;
            p4_rneg_reg <= p3_rneg_reg;
            p5_s_reg    <= p4_s_reg;
            p5_side_reg <= p5_side_next;
        end
    end

    // ---------------- square root, one root bit per stage ----------------
    logic                           sq_vld_reg  [1:RB];
    logic [sdf_pkg::SQ_REM_W-1:0]   sq_rem_reg  [1:RB];
    logic [RB-1:0]                  sq_root_reg [1:RB];
    logic [sdf_pkg::SQ_PAD_W-1:0]   sq_bits_reg [1:RB];
    sdf_pkg::sqrt_side_t            sq_side_reg [1:RB];

    for (genvar k = 0; k < RB; k++) begin : g_sqrt
        logic                          vld_cur;
        logic [sdf_pkg::SQ_REM_W-1:0]  rem_cur;
        logic [RB-1:0]                 root_cur;
        logic [sdf_pkg::SQ_PAD_W-1:0]  bits_cur;
        sdf_pkg::sqrt_side_t           side_cur;
        logic [sdf_pkg::SQ_REM_W+1:0]  rem_sh;
        logic [sdf_pkg::SQ_REM_W+1:0]  trial;
        logic                          ge;
        logic [sdf_pkg::SQ_REM_W-1:0]  rem_next;

        if (k == 0) begin : g_first
            assign vld_cur  = p5_vld_reg;
            assign rem_cur  = '0;
            assign root_cur = '0;
            assign bits_cur = sdf_pkg::SQ_PAD_W'(p5_s_reg);
            assign side_cur = p5_side_reg;
        end else begin : g_rest
            assign vld_cur  = sq_vld_reg[k];
            assign rem_cur  = sq_rem_reg[k];
            assign root_cur = sq_root_reg[k];
            assign bits_cur = sq_bits_reg[k];
            assign side_cur = sq_side_reg[k];
        end

        // bring down the next bit pair, try root*4+1
        assign rem_sh   = {rem_cur, bits_cur[sdf_pkg::SQ_PAD_W-1 -: 2]};
        assign trial    = (sdf_pkg::SQ_REM_W+2)'({root_cur, 2'b01});
        assign ge       = rem_sh >= trial;
        assign rem_next = ge ? sdf_pkg::SQ_REM_W'(rem_sh - trial)
                             : sdf_pkg::SQ_REM_W'(rem_sh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_vld_reg[k+1] <= 1'b0;
            end else if (en) begin
                sq_vld_reg[k+1] <= vld_cur;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                sq_rem_reg[k+1]  <= rem_next;
                sq_root_reg[k+1] <= {root_cur[RB-2:0], ge};
                sq_bits_reg[k+1] <= {bits_cur[sdf_pkg::SQ_PAD_W-3:0], 2'b00};
                sq_side_reg[k+1] <= side_cur;
            end
        end
    end

    // ---------------- ratio = (v.r) / |r| ----------------
    sdf_pkg::sqrt_side_t             sq_side_out;
    logic [sdf_pkg::LEN_W-1:0]       sq_len;
    sdf_pkg::ratio_side_t            rdiv_side_in;
    logic                            rdiv_vld;
    logic [sdf_pkg::RATIO_W-1:0]     rdiv_quo;
    logic [$bits(sdf_pkg::ratio_side_t)-1:0] rdiv_side_out;
    sdf_pkg::ratio_side_t            rdiv_side;

    assign sq_side_out = sq_side_reg[RB];
    assign sq_len      = sdf_pkg::LEN_W'(sq_root_reg[RB]);

    always_comb begin
        rdiv_side_in.len  = sq_len;
        rdiv_side_in.dneg = sq_side_out.dneg;
        rdiv_side_in.deg  = sq_side_out.deg;
        rdiv_side_in.rm   = sq_side_out.rm;
        rdiv_side_in.rneg = sq_side_out.rneg;
    end

    sdf_div_pipe #(
        .NUM_W  (sdf_pkg::SUM_W),
        .DEN_W  (sdf_pkg::LEN_W),
        .QUO_W  (sdf_pkg::RATIO_W),
        .SIDE_W ($bits(sdf_pkg::ratio_side_t))
    ) u_ratio_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_vld_reg[RB]),
        .num       (sq_side_out.dmag),
        .den       (sq_len),
        .side_in   (rdiv_side_in),
        .out_valid (rdiv_vld),
        .quo       (rdiv_quo),
        .side_out  (rdiv_side_out)
    );

    assign rdiv_side = rdiv_side_out;

    // ---------------- p7: |r| - rest ----------------
    logic                          p7_vld_reg;
    logic [sdf_pkg::SMAG_W-1:0]    p7_smag_reg;
    logic                          p7_sneg_reg;
    logic [sdf_pkg::RATIO_W-1:0]   p7_ratio_reg;
    sdf_pkg::ratio_side_t          p7_side_reg;
    logic [sdf_pkg::SMAG_W-1:0]    p7_diff;

    assign p7_diff = {1'b0, rdiv_side.len} - sdf_pkg::SMAG_W'(rest_length_reg);

    // ---------------- p8: gain products ----------------
    logic                          p8_vld_reg;
    logic [sdf_pkg::GPROD_W-1:0]   p8_sprod_reg;
    logic [sdf_pkg::GPROD_W-1:0]   p8_dprod_reg;
    logic                          p8_sneg_reg;
    sdf_pkg::ratio_side_t          p8_side_reg;

    // ---------------- p9: scalar force ----------------
    logic                          p9_vld_reg;
    logic [sdf_pkg::FS_W-1:0]      p9_fs_reg;
    sdf_pkg::ratio_side_t          p9_side_reg;
    logic [sdf_pkg::FS_W-1:0]      p9_sterm;
    logic [sdf_pkg::FS_W-1:0]      p9_dterm;

    // terms are Q16.16 products shifted back, magnitude truncated toward zero
    always_comb begin
        p9_sterm = sdf_pkg::FS_W'(p8_sprod_reg[sdf_pkg::GPROD_W-1:FW]);
        p9_dterm = sdf_pkg::FS_W'(p8_dprod_reg[sdf_pkg::GPROD_W-1:FW]);
        if (p8_sneg_reg) begin
            p9_sterm = ~p9_sterm + 1'b1;
        end
        if (p8_side_reg.dneg) begin
            p9_dterm = ~p9_dterm + 1'b1;
        end
    end

    // ---------------- p10: |f| ----------------
    logic                          p10_vld_reg;
    logic [sdf_pkg::FS_W-1:0]      p10_fsm_reg;
    logic                          p10_fsneg_reg;
    sdf_pkg::ratio_side_t          p10_side_reg;

    // ---------------- p11: partial products |f|*|r_i| ----------------
    logic                                  p11_vld_reg;
    logic [2:0][sdf_pkg::PART_W-1:0]       p11_lo_reg;
    logic [2:0][sdf_pkg::PART_W-1:0]       p11_hi_reg;
    logic [2:0]                            p11_negf_reg;
    logic                                  p11_deg_reg;
    logic [sdf_pkg::LEN_W-1:0]             p11_len_reg;

    // ---------------- p12: full numerators ----------------
    logic                                  p12_vld_reg;
    logic [2:0][sdf_pkg::NUM_W-1:0]        p12_num_reg;
    logic [2:0]                            p12_negf_reg;
    logic                                  p12_deg_reg;
    logic [sdf_pkg::LEN_W-1:0]             p12_len_reg;

    // ---------------- p13: early overflow check ----------------
    logic                                  p13_vld_reg;
    logic [2:0][sdf_pkg::QFN_W-1:0]        p13_num_reg;
    sdf_pkg::force_side_t [2:0]            p13_side_reg;
    logic [sdf_pkg::LEN_W-1:0]             p13_len_reg;
    logic [2:0]                            p13_ovf_next;

    // quotient reaches 2^33 exactly when num >> 33 >= len; saturates either way
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            p13_ovf_next[i] = p12_num_reg[i][sdf_pkg::NUM_W-1:sdf_pkg::QF_W]
                            >= (sdf_pkg::NUM_W - sdf_pkg::QF_W)'(p12_len_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p7_vld_reg  <= 1'b0;
            p8_vld_reg  <= 1'b0;
            p9_vld_reg  <= 1'b0;
            p10_vld_reg <= 1'b0;
            p11_vld_reg <= 1'b0;
            p12_vld_reg <= 1'b0;
            p13_vld_reg <= 1'b0;
        end else if (en) begin
            p7_vld_reg  <= rdiv_vld;
            p8_vld_reg  <= p7_vld_reg;
            p9_vld_reg  <= p8_vld_reg;
            p10_vld_reg <= p9_vld_reg;
            p11_vld_reg <= p10_vld_reg;
            p12_vld_reg <= p11_vld_reg;
            p13_vld_reg <= p12_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // p7
            p7_sneg_reg  <= p7_diff[sdf_pkg::SMAG_W-1];
            p7_smag_reg  <= p7_diff[sdf_pkg::SMAG_W-1] ? (~p7_diff + 1'b1) : p7_diff;
            p7_ratio_reg <= rdiv_quo;
            p7_side_reg  <= rdiv_side;
            // p8
            p8_sprod_reg <= spring_gain_reg * p7_smag_reg;
            p8_dprod_reg <= damper_gain_reg * p7_ratio_reg;
            p8_sneg_reg  <= p7_sneg_reg;
            p8_side_reg  <= p7_side_reg;
            // p9
            p9_fs_reg    <= p9_sterm + p9_dterm;
            p9_side_reg  <= p8_side_reg;
            // p10
            p10_fsneg_reg <= p9_fs_reg[sdf_pkg::FS_W-1];
            p10_fsm_reg   <= p9_fs_reg[sdf_pkg::FS_W-1] ? (~p9_fs_reg + 1'b1) : p9_fs_reg;
            p10_side_reg  <= p9_side_reg;
            // p11
            for (int i = 0; i < 3; i++) begin
                p11_lo_reg[i]   <= p10_fsm_reg[sdf_pkg::FS_HALF_W-1:0] * p10_side_reg.rm[i];
                p11_hi_reg[i]   <= p10_fsm_reg[sdf_pkg::FS_W-1:sdf_pkg::FS_HALF_W]
                                 * p10_side_reg.rm[i];
                p11_negf_reg[i] <= p10_fsneg_reg ^ p10_side_reg.rneg[i];
            end
            p11_deg_reg <= p10_side_reg.deg;
            p11_len_reg <= p10_side_reg.len;
            // p12
            for (int i = 0; i < 3; i++) begin
                p12_num_reg[i] <= (sdf_pkg::NUM_W'(p11_hi_reg[i]) << sdf_pkg::FS_HALF_W)
                                + sdf_pkg::NUM_W'(p11_lo_reg[i]);
            end
            p12_negf_reg <= p11_negf_reg;
            p12_deg_reg  <= p11_deg_reg;
            p12_len_reg  <= p11_len_reg;
            // p13
            for (int i = 0; i < 3; i++) begin
                p13_num_reg[i]       <= p13_ovf_next[i] ? '0
                                      : p12_num_reg[i][sdf_pkg::QFN_W-1:0];
                p13_side_reg[i].negf <= p12_negf_reg[i];
                p13_side_reg[i].ovf  <= p13_ovf_next[i];
                p13_side_reg[i].deg  <= p12_deg_reg;
            end
            p13_len_reg <= p12_len_reg;
        end
    end

    // ---------------- force components: |f|*|r_i| / |r| ----------------
    logic [2:0]                        fdiv_vld;
    logic [2:0][sdf_pkg::QF_W-1:0]     fdiv_quo;
    sdf_pkg::force_side_t [2:0]        fdiv_side;
    logic [DW-1:0]                     force_sat [3];

    for (genvar i = 0; i < 3; i++) begin : g_force
        logic [$bits(sdf_pkg::force_side_t)-1:0] side_out;

        sdf_div_pipe #(
            .NUM_W  (sdf_pkg::QFN_W),
            .DEN_W  (sdf_pkg::LEN_W),
            .QUO_W  (sdf_pkg::QF_W),
            .SIDE_W ($bits(sdf_pkg::force_side_t))
        ) u_force_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (p13_vld_reg),
            .num       (p13_num_reg[i]),
            .den       (p13_len_reg),
            .side_in   (p13_side_reg[i]),
            .out_valid (fdiv_vld[i]),
            .quo       (fdiv_quo[i]),
            .side_out  (side_out)
        );

        assign fdiv_side[i] = side_out;

        // saturate to signed Q16.16, coincident particles give zero
        always_comb begin
            if (fdiv_side[i].deg) begin
                force_sat[i] = '0;
            end else if (fdiv_side[i].negf) begin
                if (fdiv_side[i].ovf || fdiv_quo[i] > sdf_pkg::QF_W'(33'h0_8000_0000)) begin
                    force_sat[i] = 32'h8000_0000;
                end else begin
                    force_sat[i] = DW'(~fdiv_quo[i] + 1'b1);
                end
            end else begin
                if (fdiv_side[i].ovf || fdiv_quo[i] > sdf_pkg::QF_W'(33'h0_7FFF_FFFF)) begin
                    force_sat[i] = 32'h7FFF_FFFF;
                end else begin
                    force_sat[i] = DW'(fdiv_quo[i]);
                end
            end
        end
    end

    // all three lanes move together
    assign last_vld = fdiv_vld[0] & fdiv_vld[1] & fdiv_vld[2];

    // ---------------- output register ----------------
    logic [DW-1:0] m_force_x_reg;
    logic [DW-1:0] m_force_y_reg;
    logic [DW-1:0] m_force_z_reg;
    logic          m_degenerate_reg;
    logic          out_load;

    assign out_load = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= last_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_force_x_reg    <= force_sat[0];
            m_force_y_reg    <= force_sat[1];
            m_force_z_reg    <= force_sat[2];
            m_degenerate_reg <= fdiv_side[0].deg;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_force_x    = m_force_x_reg;
    assign m_force_y    = m_force_y_reg;
    assign m_force_z    = m_force_z_reg;
    assign m_degenerate = m_degenerate_reg;

endmodule

@@ rtl/core/sdf_checker.sv @@
// port-level checks for the spring-damper force block, bound to the top level
// depends on sdf_pkg and spring_damper_force_top

module sdf_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_ready,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [sdf_pkg::DATA_W-1:0] m_force_x,
    input logic signed [sdf_pkg::DATA_W-1:0] m_force_y,
    input logic signed [sdf_pkg::DATA_W-1:0] m_force_z,
    input logic                              m_degenerate
);

    // reset empties the result side
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result beat valid right after reset");

    // a stalled result beat holds
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_force_x) && $stable(m_force_y)
                                && $stable(m_force_z) && $stable(m_degenerate))
        else $error("stalled result beat changed");

    // coincident particles give zero force
    a_degenerate_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> m_force_x == 0 && m_force_y == 0 && m_force_z == 0)
        else $error("degenerate beat with nonzero force");

    // an empty output never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output register");

endmodule

bind spring_damper_force_top sdf_checker u_sdf_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_force_x    (m_force_x),
    .m_force_y    (m_force_y),
    .m_force_z    (m_force_z),
    .m_degenerate (m_degenerate)
);
